// ===== hw/rtl/pwfd_pkg.sv =====
package pwfd_pkg;

  // Default duration width, one tick is 100 us
  localparam int DurationBitsDef = 16;

  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 3;
  localparam int FrameBits = 32;
  localparam int CountW    = 6;
  localparam int ByteW     = 8;

  // Result word: check_passed, address, command, bits_received, zero pad
  localparam int ResW = 1 + 2 * ByteW + CountW;
  localparam int OutW = ((ResW + 7) / 8) * 8;

  localparam logic [CfgW-1:0] LeaderLowMinRst  = 16'd80;
  localparam logic [CfgW-1:0] LeaderLowMaxRst  = 16'd100;
  localparam logic [CfgW-1:0] LeaderHighMinRst = 16'd40;
  localparam logic [CfgW-1:0] LeaderHighMaxRst = 16'd50;
  localparam logic [CfgW-1:0] BitMinRst        = 16'd4;
  localparam logic [CfgW-1:0] BitLowMaxRst     = 16'd9;
  localparam logic [CfgW-1:0] BitHighMaxRst    = 16'd19;
  localparam logic [CfgW-1:0] OneThresholdRst  = 16'd10;

  typedef enum logic [CfgIdxW-1:0] {
    RegLeaderLowMin  = 3'd0,
    RegLeaderLowMax  = 3'd1,
    RegLeaderHighMin = 3'd2,
    RegLeaderHighMax = 3'd3,
    RegBitMin        = 3'd4,
    RegBitLowMax     = 3'd5,
    RegBitHighMax    = 3'd6,
    RegOneThreshold  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] leader_low_min;
    logic [CfgW-1:0] leader_low_max;
    logic [CfgW-1:0] leader_high_min;
    logic [CfgW-1:0] leader_high_max;
    logic [CfgW-1:0] bit_min;
    logic [CfgW-1:0] bit_low_max;
    logic [CfgW-1:0] bit_high_max;
    logic [CfgW-1:0] one_threshold;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] bits_received;
    logic [ByteW-1:0]  command;
    logic [ByteW-1:0]  address;
    logic              check_passed;
  } res_t;

endpackage

// ===== hw/rtl/pwfd_cfg.sv =====
module pwfd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pwfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pwfd_pkg::CfgW-1:0]     cfg_data_i,
  output pwfd_pkg::cfg_t                cfg_o
);
  import pwfd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        RegLeaderLowMin:  cfg_d.leader_low_min  = cfg_data_i;
        RegLeaderLowMax:  cfg_d.leader_low_max  = cfg_data_i;
        RegLeaderHighMin: cfg_d.leader_high_min = cfg_data_i;
        RegLeaderHighMax: cfg_d.leader_high_max = cfg_data_i;
        RegBitMin:        cfg_d.bit_min         = cfg_data_i;
        RegBitLowMax:     cfg_d.bit_low_max     = cfg_data_i;
        RegBitHighMax:    cfg_d.bit_high_max    = cfg_data_i;
        RegOneThreshold:  cfg_d.one_threshold   = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low_min  <= LeaderLowMinRst;
      cfg_q.leader_low_max  <= LeaderLowMaxRst;
      cfg_q.leader_high_min <= LeaderHighMinRst;
      cfg_q.leader_high_max <= LeaderHighMaxRst;
      cfg_q.bit_min         <= BitMinRst;
      cfg_q.bit_low_max     <= BitLowMaxRst;
      cfg_q.bit_high_max    <= BitHighMaxRst;
      cfg_q.one_threshold   <= OneThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/pwfd_decode.sv =====
module pwfd_decode #(
  parameter int DURATION_BITS = pwfd_pkg::DurationBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pwfd_pkg::cfg_t           cfg_i,
  input  logic                     adv_i,    // word in the input register moves on
  input  logic                     func_i,   // 0 = end of low, 1 = end of high
  input  logic [DURATION_BITS-1:0] dur_i,
  output logic                     done_o,   // this word closes a frame
  output pwfd_pkg::res_t           res_o
);
  import pwfd_pkg::*;

  localparam int CmpW = (DURATION_BITS > CfgW) ? DURATION_BITS : CfgW;

  logic                     receiving_q, receiving_d;
  logic [CountW-1:0]        bit_count_q, bit_count_d;
  logic [FrameBits-1:0]     shift_q, shift_d;
  logic [DURATION_BITS-1:0] last_low_q, last_low_d;

  logic [CmpW-1:0]      low_x, dur_x;
  logic                 leader_ok, bit_ok, one_bit;
  logic [CountW-1:0]    count_inc, count_sel;
  logic [FrameBits-1:0] shift_ext, word_sel;
  logic [ByteW-1:0]     b3, b2, b1, b0;

  assign low_x = CmpW'(last_low_q);
  assign dur_x = CmpW'(dur_i);

  assign leader_ok = (low_x >= CmpW'(cfg_i.leader_low_min))  &&
                     (low_x <= CmpW'(cfg_i.leader_low_max))  &&
                     (dur_x >= CmpW'(cfg_i.leader_high_min)) &&
                     (dur_x <= CmpW'(cfg_i.leader_high_max));

  assign bit_ok = (low_x >= CmpW'(cfg_i.bit_min))      &&
                  (low_x <= CmpW'(cfg_i.bit_low_max))  &&
                  (dur_x >= CmpW'(cfg_i.bit_min))      &&
                  (dur_x <= CmpW'(cfg_i.bit_high_max));

  assign one_bit   = dur_x >= CmpW'(cfg_i.one_threshold);
  assign shift_ext = {shift_q[FrameBits-2:0], one_bit};
  assign count_inc = bit_count_q + CountW'(1);

  // Out-of-window pair ends the frame with the word as it stands
  assign word_sel  = bit_ok ? shift_ext : shift_q;
  assign count_sel = bit_ok ? count_inc : bit_count_q;

  assign done_o = func_i && receiving_q &&
                  (!bit_ok || (count_inc == CountW'(FrameBits)));

  assign b3 = word_sel[4*ByteW-1:3*ByteW];
  assign b2 = word_sel[3*ByteW-1:2*ByteW];
  assign b1 = word_sel[2*ByteW-1:ByteW];
  assign b0 = word_sel[ByteW-1:0];

  assign res_o.check_passed  = ((~b3) == b2) && ((~b1) == b0);
  assign res_o.address       = b3;
  assign res_o.command       = b1;
  assign res_o.bits_received = count_sel;

  always_comb begin
    receiving_d = receiving_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    last_low_d  = last_low_q;
    if (adv_i) begin
      if (!func_i) begin
        last_low_d = dur_i;
      end else if (!receiving_q) begin
        if (leader_ok) begin
          receiving_d = 1'b1;
          bit_count_d = '0;
          shift_d     = '0;
        end
      end else begin
        shift_d     = word_sel;
        bit_count_d = count_sel;
        if (done_o) begin
          receiving_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      bit_count_q <= '0;
      shift_q     <= '0;
      last_low_q  <= '0;
    end else begin
      receiving_q <= receiving_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      last_low_q  <= last_low_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_count_q <= CountW'(FrameBits))
    else $error("bit count beyond frame length");

  a_done_only_receiving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && done_o) |-> (receiving_q && func_i))
    else $error("frame end outside a frame");

  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && done_o) |=> !receiving_q)
    else $error("decoder still receiving after frame end");

  a_low_keeps_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && !func_i) |=> ($stable(receiving_q) && $stable(bit_count_q)))
    else $error("low event changed decoder mode");

endmodule

// ===== hw/rtl/pulse_width_frame_decoder_unit.sv =====
// Pulse-width frame decoder for NEC-style IR remotes (MSB-first variant). Each
// input word is one measured phase: tuser=0 marks the end of a low phase and
// only stores its length, tuser=1 marks the end of a high phase and pairs it
// with the stored low length. In idle a pair inside the leader windows opens a
// frame; while receiving each in-window pair shifts one bit in (one when the
// high length is at or above one_threshold). After 32 bits, or on an
// out-of-window pair, one result word is emitted with the inverse-byte check,
// address, command and bit count, and the decoder returns to idle. Windows are
// inclusive and set through the write port (index 0..7 in register order);
// the user must write them only while no frame is in flight, which the block
// itself does not enforce. Throughput is one word per clock unless the input
// side stalls: the decode is a single compare-and-shift pass between the input
// register and the result register.
// The input side stalls only when a frame-ending word meets an occupied result
// register that the sink is not taking.
module pulse_width_frame_decoder_unit #(
  parameter int DURATION_BITS = pwfd_pkg::DurationBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [pwfd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pwfd_pkg::CfgW-1:0]           cfg_data_i,
  // phase words
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((DURATION_BITS+7)/8)*8-1:0]  s_axis_tdata,  // duration, zero pad
  input  logic                                s_axis_tuser,  // func
  // frame results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // check_passed, address, command, bits_received, zero pad
  output logic [pwfd_pkg::OutW-1:0]           m_axis_tdata
);
  import pwfd_pkg::*;

  cfg_t cfg;

  // input register
  logic                     in_valid_q, in_valid_d;
  logic                     in_func_q;
  logic [DURATION_BITS-1:0] in_dur_q;

  // result register
  logic out_valid_q, out_valid_d;
  res_t out_res_q;

  logic adv, dec_done, in_take;
  res_t dec_res;

  pwfd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pwfd_decode #(
    .DURATION_BITS (DURATION_BITS)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .adv_i  (adv),
    .func_i (in_func_q),
    .dur_i  (in_dur_q),
    .done_o (dec_done),
    .res_o  (dec_res)
  );

  // A word that ends no frame never needs the result slot.
  assign adv = in_valid_q && (!dec_done || !out_valid_q || m_axis_tready);

  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && dec_done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_func_q <= s_axis_tuser;
      in_dur_q  <= s_axis_tdata[DURATION_BITS-1:0];
    end
    if (adv && dec_done) begin
      out_res_q <= dec_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_res_q);

endmodule

// ===== verif/pulse_width_frame_decoder_unit_test.sv =====
`timescale 1ns / 100ps

// Phase words go in on the s_axis side: tuser picks low or high end, tdata
// holds the length in ticks. Frame results come out on m_axis and are checked
// field by field against a local decoder model kept in step with every
// accepted word.
module pulse_width_frame_decoder_unit_test;
  import pwfd_pkg::*;

  // tuser codes on the input side
  localparam bit PhaseLow  = 1'b0;
  localparam bit PhaseHigh = 1'b1;

  localparam int DurW        = DurationBitsDef;
  localparam int DrainCycles = 8;       // drain margin after the last result
  localparam int HoldCycles  = 500;     // long sink stall for the pressure test
  localparam int CycleLimit  = 200000;  // watchdog limit for the whole run

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgW-1:0]      cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DurW-1:0]      s_axis_tdata  = '0;   // duration
  logic                 s_axis_tuser  = 1'b0; // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // check_passed, address, command, bits_received, zero pad
  logic [OutW-1:0]      m_axis_tdata;

  pulse_width_frame_decoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Decoder model: window registers plus the frame state
  // ---------------------------------------------------------------------
  logic [CfgW-1:0] win [8];
  bit              rx_busy;     // leader seen, shifting bits
  logic [5:0]      rx_count;
  logic [31:0]     rx_shift;
  logic [DurW-1:0] low_len;     // last low phase, never cleared by decoding

  res_t frame_q [$];            // expected frame results, oldest first

  int  words_sent;
  int  frames_checked;
  int  good_frames;
  int  errors;
  int  cycle_cnt;
  bit  calm;                    // no random idling on either side
  bit  hold_rx;                 // sink held off by the pressure test

  initial begin
    win[RegLeaderLowMin]  = LeaderLowMinRst;
    win[RegLeaderLowMax]  = LeaderLowMaxRst;
    win[RegLeaderHighMin] = LeaderHighMinRst;
    win[RegLeaderHighMax] = LeaderHighMaxRst;
    win[RegBitMin]        = BitMinRst;
    win[RegBitLowMax]     = BitLowMaxRst;
    win[RegBitHighMax]    = BitHighMaxRst;
    win[RegOneThreshold]  = OneThresholdRst;
    rx_busy  = 1'b0;
    rx_count = '0;
    rx_shift = '0;
    low_len  = '0;
  end

  function automatic bit in_window(logic [CfgW-1:0] t, logic [CfgW-1:0] lo,
                                   logic [CfgW-1:0] hi);
    return t >= lo && t <= hi;
  endfunction

  // Advance the model by one accepted word; returns 1 when a frame ends.
  function automatic bit decode_phase(input bit func, input logic [DurW-1:0] dur,
                                      output res_t r);
    logic [7:0] b3, b2, b1, b0;
    bit         done;
    r    = '0;
    done = 1'b0;
    if (func == PhaseLow) begin
      low_len = dur;
      return 1'b0;
    end
    if (!rx_busy) begin
      // idle: only a pair inside both leader windows opens a frame
      if (in_window(low_len, win[RegLeaderLowMin], win[RegLeaderLowMax]) &&
          in_window(dur, win[RegLeaderHighMin], win[RegLeaderHighMax])) begin
        rx_busy  = 1'b1;
        rx_count = '0;
        rx_shift = '0;
      end
      return 1'b0;
    end
    if (!in_window(low_len, win[RegBitMin], win[RegBitLowMax]) ||
        !in_window(dur, win[RegBitMin], win[RegBitHighMax])) begin
      done = 1'b1;  // broken pair: close on what was shifted so far
    end else begin
      rx_shift = {rx_shift[30:0], dur >= win[RegOneThreshold]};
      rx_count = rx_count + 6'd1;
      if (rx_count >= FrameBits) done = 1'b1;
    end
    if (!done) return 1'b0;
    {b3, b2, b1, b0} = rx_shift;
    r.check_passed  = (~b3 == b2) && (~b1 == b0);
    r.address       = b3;
    r.command       = b1;
    r.bits_received = rx_count;
    rx_busy = 1'b0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Sink side: random ready, plus a long hold when asked
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_rx)   m_axis_tready <= 1'b0;
    else if (calm) m_axis_tready <= 1'b1;
    else           m_axis_tready <= ($urandom_range(99) >= 6);
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[ResW-1:0]);
      if (frame_q.size() == 0) begin
        $error("result word %h with no frame pending", m_axis_tdata);
        errors++;
      end else begin
        want = frame_q.pop_front();
        frames_checked++;
        if (got.check_passed) good_frames++;
        if (got.check_passed != want.check_passed) begin
          $error("check_passed: expected %0d, actual %0d",
                 want.check_passed, got.check_passed);
          errors++;
        end
        if (got.address != want.address) begin
          $error("address: expected %h, actual %h", want.address, got.address);
          errors++;
        end
        if (got.command != want.command) begin
          $error("command: expected %h, actual %h", want.command, got.command);
          errors++;
        end
        if (got.bits_received != want.bits_received) begin
          $error("bits_received: expected %0d, actual %0d",
                 want.bits_received, got.bits_received);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d frames still pending",
               cycle_cnt, frame_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------
  // One phase word. tvalid stays high between back-to-back words; it is
  // only dropped here when a random gap is taken.
  task automatic send_word(input bit func, input logic [DurW-1:0] dur);
    int   gap;
    res_t r;
    gap = 0;
    if (!calm && $urandom_range(99) < 6) gap = int'($urandom_range(5, 1));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= dur;
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (decode_phase(func, dur, r)) frame_q.push_back(r);
  endtask

  task automatic send_pair(input logic [DurW-1:0] lo_len, input logic [DurW-1:0] hi_len);
    send_word(PhaseLow, lo_len);
    send_word(PhaseHigh, hi_len);
  endtask

  // Any length at all
  function automatic logic [DurW-1:0] any_len();
    return DurW'($urandom_range(16'hFFFF, 0));
  endfunction

  // Value inside [lo, hi]; anything at all when the window is empty
  function automatic logic [DurW-1:0] pick(logic [CfgW-1:0] lo, logic [CfgW-1:0] hi);
    if (lo <= hi) return DurW'($urandom_range(hi, lo));
    return any_len();
  endfunction

  // Leader, then a full or cut-short run of bits for a random word
  task automatic send_frame();
    logic [31:0]     word;
    logic [7:0]      a, c;
    logic [CfgW-1:0] lo, hi, thr;
    int              nbits;
    bit              b;
    send_pair(pick(win[RegLeaderLowMin], win[RegLeaderLowMax]),
              pick(win[RegLeaderHighMin], win[RegLeaderHighMax]));
    a = 8'($urandom_range(255, 0));
    c = 8'($urandom_range(255, 0));
    word  = $urandom_range(1, 0) ? {a, ~a, c, ~c} : $urandom();
    nbits = ($urandom_range(99) < 70) ? 32 : int'($urandom_range(31, 0));
    thr   = win[RegOneThreshold];
    for (int i = 0; i < nbits; i++) begin
      b = word[31-i];
      if (b) begin
        lo = (thr > win[RegBitMin]) ? thr : win[RegBitMin];
        hi = win[RegBitHighMax];
      end else begin
        lo = win[RegBitMin];
        if (thr == 0) hi = '0;
        else hi = (thr - 16'd1 < win[RegBitHighMax]) ? thr - 16'd1 : win[RegBitHighMax];
        if (thr == 0) lo = 16'd1;  // no zero possible: take anything
      end
      send_pair(pick(win[RegBitMin], win[RegBitLowMax]), pick(lo, hi));
    end
    // short frames end on a random pair, usually out of window
    if (nbits < 32) send_pair(any_len(), any_len());
  endtask

  // Mostly frames, some loose phase words
  task automatic run_mix(input int n);
    int start;
    start = words_sent;
    while (words_sent - start < n) begin
      if ($urandom_range(99) < 80) send_frame();
      else send_word(1'($urandom_range(1, 0)), any_len());
    end
  endtask

  // Force any open frame to end, then let the results drain
  task automatic settle();
    logic [DurW-1:0] lo_len;
    while (rx_busy) begin
      if (win[RegBitMin] > 0)                lo_len = '0;
      else if (win[RegBitLowMax] < 16'hFFFF) lo_len = 16'hFFFF;
      else                                   lo_len = win[RegBitMin];  // windows wide open
      send_pair(lo_len, win[RegBitMin]);
    end
    s_axis_tvalid <= 1'b0;
    while (frame_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    win[idx] = val;
  endtask

  task automatic set_windows(input cfg_t c);
    settle();
    write_reg(RegLeaderLowMin,  c.leader_low_min);
    write_reg(RegLeaderLowMax,  c.leader_low_max);
    write_reg(RegLeaderHighMin, c.leader_high_min);
    write_reg(RegLeaderHighMax, c.leader_high_max);
    write_reg(RegBitMin,        c.bit_min);
    write_reg(RegBitLowMax,     c.bit_low_max);
    write_reg(RegBitHighMax,    c.bit_high_max);
    write_reg(RegOneThreshold,  c.one_threshold);
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t reset_windows();
    cfg_t c;
    c.leader_low_min  = LeaderLowMinRst;
    c.leader_low_max  = LeaderLowMaxRst;
    c.leader_high_min = LeaderHighMinRst;
    c.leader_high_max = LeaderHighMaxRst;
    c.bit_min         = BitMinRst;
    c.bit_low_max     = BitLowMaxRst;
    c.bit_high_max    = BitHighMaxRst;
    c.one_threshold   = OneThresholdRst;
    return c;
  endfunction

  function automatic cfg_t uniform_windows(logic [CfgW-1:0] lo, logic [CfgW-1:0] hi,
                                           logic [CfgW-1:0] thr);
    cfg_t c;
    c.leader_low_min  = lo;
    c.leader_low_max  = hi;
    c.leader_high_min = lo;
    c.leader_high_max = hi;
    c.bit_min         = lo;
    c.bit_low_max     = hi;
    c.bit_high_max    = hi;
    c.one_threshold   = thr;
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Reset windows, hand-picked edges of every window
  task automatic test_directed();
    send_word(PhaseHigh, 16'd45);     // high with no low yet: low is zero, ignored
    send_pair(16'd100, 16'd40);       // leader at low max / high min
    send_pair(16'd4, 16'd19);         // one at the top of the high window
    send_pair(16'd9, 16'd9);          // zero just under the threshold
    send_pair(16'd4, 16'd10);         // one exactly at the threshold
    send_pair(16'd3, 16'd10);         // low under bit_min ends the frame, 3 bits
    send_pair(16'd79, 16'd45);        // idle, leader low just short: ignored
    send_pair(16'd80, 16'd51);        // idle, leader high just long: ignored
    send_pair(16'd80, 16'd50);        // leader at low min / high max
    send_word(PhaseHigh, 16'd12);     // reuses low of 80: out of window, 0 bits
    send_pair(16'hFFFF, 16'hFFFF);    // all-ones lengths in idle
    send_pair(16'd0, 16'd0);          // all-zero lengths in idle
    send_pair(16'd90, 16'd45);        // leader
    send_pair(16'd4, 16'd20);         // high over bit_high_max ends, 0 bits
    settle();
  endtask

  task automatic test_reset_windows();
    run_mix(300);
  endtask

  // Every length in window: every pair is a leader or a bit, frames run to 32
  task automatic test_open_windows();
    set_windows(uniform_windows(16'd0, 16'hFFFF, 16'h8000));
    run_mix(200);
    set_windows(uniform_windows(16'd0, 16'hFFFF, 16'd0));      // all ones
    run_mix(60);
    set_windows(uniform_windows(16'd0, 16'hFFFF, 16'hFFFF));   // ones only at max
    run_mix(60);
  endtask

  // Single-value windows at both ends of the range
  task automatic test_pinned_windows();
    set_windows(uniform_windows(16'hFFFF, 16'hFFFF, 16'hFFFF));
    run_mix(125);
    set_windows(uniform_windows(16'd0, 16'd0, 16'd0));
    run_mix(125);
  endtask

  // Random narrow windows; the middle setting runs with no idling at all
  task automatic test_random_windows();
    cfg_t c;
    logic [CfgW-1:0] base;
    for (int k = 0; k < 3; k++) begin
      base = CfgW'($urandom_range(16'hFF00, 0));
      c.leader_low_min  = base;
      c.leader_low_max  = base + CfgW'($urandom_range(255, 0));
      base = CfgW'($urandom_range(16'hFF00, 0));
      c.leader_high_min = base;
      c.leader_high_max = base + CfgW'($urandom_range(255, 0));
      c.bit_min         = CfgW'($urandom_range(300, 0));
      c.bit_low_max     = c.bit_min + CfgW'($urandom_range(50, 0));
      c.bit_high_max    = c.bit_min + CfgW'($urandom_range(100, 0));
      c.one_threshold   = c.bit_min + CfgW'($urandom_range(100, 0));
      set_windows(c);
      calm = (k == 1);
      run_mix(100);
      calm = 1'b0;
    end
  endtask

  // min above max everywhere: nothing should ever decode
  task automatic test_closed_windows();
    set_windows(uniform_windows(16'd1000, 16'd999, 16'd0));
    run_mix(80);
  endtask

  // Sink stalls for a long stretch while short frames keep coming; the
  // result register fills and the input side must back up.
  task automatic test_backpressure();
    set_windows(reset_windows());
    fork
      begin
        hold_rx <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      begin
        for (int i = 0; i < 40; i++) begin
          send_pair(pick(LeaderLowMinRst, LeaderLowMaxRst),
                    pick(LeaderHighMinRst, LeaderHighMaxRst));
          send_pair(16'd0, 16'd0);   // broken at once: 0-bit frame
        end
      end
    join
    run_mix(60);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_reset_windows();
    test_open_windows();
    test_pinned_windows();
    test_random_windows();
    test_closed_windows();
    test_backpressure();

    settle();
    $display("covered: %0d phase words, %0d frames checked (%0d with a good inverse check)",
             words_sent, frames_checked, good_frames);
    $display("windows: reset, wide open, pinned at 0 and max, random, closed; long sink stall");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
